>>> hdl/bdh_pkg.sv
package bdh_pkg;

    typedef struct packed {
        logic               func;
        logic               side;
        logic               snapshot;
        logic [2:0]         level;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
        logic [13:0]        bin;
    } t_in;

    typedef struct packed {
        logic [13:0]        bin_index;
        logic signed [63:0] exposure_total;
        logic signed [63:0] event_total;
    } t_out;

    typedef enum logic [1:0] {
        CMD_LOAD_PREV,
        CMD_LOAD_CUR,
        CMD_WALK,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               side;
        logic [2:0]         level;
        logic signed [31:0] price;
        logic signed [31:0] quantity;
        logic [13:0]        bin;
        logic               bin_oob;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BEST,
        S_FETCH,
        S_EVAL,
        S_UPD,
        S_RD
    } t_state;

    localparam logic FUNC_READ = 1'b1;
    localparam logic SNAP_CUR  = 1'b1;

    function automatic logic signed [32:0] bdh_dist(input logic side,
                                                    input logic signed [31:0] price,
                                                    input logic signed [31:0] ref_price);
        logic signed [32:0] p;
        logic signed [32:0] r;
        p = {price[31], price};
        r = {ref_price[31], ref_price};
        return side ? (r - p) : (p - r);
    endfunction

endpackage

>>> hdl/bdh_ram.sv
module bdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/bdh_front.sv
module bdh_front import bdh_pkg::*; #(
    parameter int LEVELS = 8,
    parameter int BINS   = 16384
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc, w_keep;
    t_cmd       w_cmd;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_acc       = push && !full;

    always_comb begin
        w_cmd.side     = i_item.side;
        w_cmd.level    = i_item.level;
        w_cmd.price    = i_item.price;
        w_cmd.quantity = i_item.quantity;
        w_cmd.bin      = i_item.bin;
        w_cmd.bin_oob  = (32'(i_item.bin) >= 32'(BINS));
        w_keep         = 1'b1;
        if (i_item.func == FUNC_READ) begin
            w_cmd.kind = CMD_READ;
        end else if (32'(i_item.level) >= 32'(LEVELS)) begin
            w_cmd.kind = CMD_LOAD_PREV;
            w_keep     = 1'b0;
        end else if (i_item.snapshot != SNAP_CUR) begin
            w_cmd.kind = CMD_LOAD_PREV;
        end else if (32'(i_item.level) == 32'(LEVELS - 1)) begin
            w_cmd.kind = CMD_WALK;
        end else begin
            w_cmd.kind = CMD_LOAD_CUR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_keep) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc && w_keep) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_acc && w_keep) - 2'(i_cmd_pop);
        end
    end
endmodule

>>> hdl/bdh_back.sv
module bdh_back import bdh_pkg::*; #(
    parameter int LEVELS = 8,
    parameter int BINS   = 16384
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic empty,
    input  logic pop,
    output t_out o_item
);
    localparam int AW = $clog2(2 * LEVELS);
    localparam int HW = $clog2(BINS);
    localparam int CW = $clog2(LEVELS + 1);

    t_state r_state, n_state;
    logic [HW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_k, n_k, r_i, n_i, r_j, n_j;
    logic r_ev, n_ev, r_side, n_side, r_upd_ev, n_upd_ev;
    logic signed [31:0] r_best, n_best;
    logic [HW-1:0] r_haddr, n_haddr;
    logic [63:0] r_amt, n_amt;
    logic [13:0] r_rd_bin, n_rd_bin;
    logic r_rd_oob, n_rd_oob;
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    logic [AW-1:0] w_base, w_cmd_addr, w_prev_raddr, w_cur_raddr;
    logic w_snap_we_p, w_snap_we_c;
    logic [63:0] w_prev_rd, w_cur_rd;
    logic w_h_we;
    logic [HW-1:0] w_h_waddr, w_h_raddr;
    logic [127:0] w_h_wdata, w_h_rd;
    logic signed [31:0] w_pp, w_pq, w_cp, w_cq;
    logic signed [32:0] w_d_best, w_d_merge, w_shrink;
    logic w_in_rng, w_stop;

    assign w_base     = r_side ? AW'(LEVELS) : AW'(0);
    assign w_cmd_addr = (i_cmd.side ? AW'(LEVELS) : AW'(0)) + AW'(i_cmd.level);
    assign w_pp = w_prev_rd[63:32];
    assign w_pq = w_prev_rd[31:0];
    assign w_cp = w_cur_rd[63:32];
    assign w_cq = w_cur_rd[31:0];
    assign w_d_best  = bdh_dist(r_side, w_pp, r_best);
    assign w_d_merge = bdh_dist(r_side, w_cp, w_pp);
    assign w_shrink  = {w_pq[31], w_pq} - {w_cq[31], w_cq};
    assign w_in_rng  = !w_d_best[32] && (w_d_best[31:0] < 32'(BINS));
    assign w_stop    = r_ev && ((32'(r_i) >= 32'(LEVELS)) || (32'(r_j) >= 32'(LEVELS)));

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid &&
                       ((i_cmd.kind != CMD_READ) || !r_out_valid);
    assign empty  = !r_out_valid;
    assign o_item = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == HW'(BINS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.kind == CMD_WALK) n_state = S_BEST;
                else if (o_cmd_pop && i_cmd.kind == CMD_READ) n_state = S_RD;
            end
            S_BEST:  n_state = S_FETCH;
            S_FETCH: n_state = w_stop ? S_IDLE : S_EVAL;
            S_EVAL: begin
                if (!r_ev) begin
                    n_state = (w_pq != 0 && w_in_rng) ? S_UPD : S_FETCH;
                end else if (w_pq == 0 || w_cq == 0) begin
                    n_state = S_IDLE;
                end else if (w_d_merge[32]) begin
                    n_state = S_FETCH;
                end else if (w_d_merge == 33'sd0) begin
                    n_state = (r_i != '0 && w_shrink > 33'sd0 && w_in_rng) ? S_UPD : S_FETCH;
                end else begin
                    n_state = (r_i != '0 && w_in_rng) ? S_UPD : S_FETCH;
                end
            end
            S_UPD:   n_state = S_FETCH;
            S_RD:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr = r_clr; n_k = r_k; n_i = r_i; n_j = r_j; n_ev = r_ev;
        n_side = r_side; n_upd_ev = r_upd_ev; n_best = r_best;
        n_haddr = r_haddr; n_amt = r_amt; n_rd_bin = r_rd_bin; n_rd_oob = r_rd_oob;
        n_out_valid = r_out_valid && !pop; n_out = r_out;
        w_snap_we_p = 1'b0; w_snap_we_c = 1'b0;
        w_prev_raddr = w_base + AW'(r_ev ? r_i : r_k);
        w_cur_raddr  = w_base + AW'(r_j);
        w_h_we = 1'b0; w_h_waddr = r_haddr; w_h_wdata = w_h_rd;
        w_h_raddr = w_d_best[HW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_h_we = 1'b1; w_h_waddr = r_clr; w_h_wdata = '0;
                n_clr = r_clr + HW'(1);
            end
            S_IDLE: begin
                w_h_raddr = HW'(i_cmd.bin);
                w_prev_raddr = (i_cmd.side ? AW'(LEVELS) : AW'(0));
                if (o_cmd_pop) begin
                    w_snap_we_p = (i_cmd.kind == CMD_LOAD_PREV);
                    w_snap_we_c = (i_cmd.kind == CMD_LOAD_CUR) || (i_cmd.kind == CMD_WALK);
                    n_side = i_cmd.side;
                    n_rd_bin = i_cmd.bin;
                    n_rd_oob = i_cmd.bin_oob;
                end
            end
            S_BEST: begin
                n_best = w_pp;
                n_k = CW'(1); n_i = '0; n_j = '0; n_ev = 1'b0;
                w_prev_raddr = w_base + AW'(1);
            end
            S_FETCH: ;
            S_EVAL: begin
                n_haddr = w_d_best[HW-1:0];
                if (!r_ev) begin
                    n_amt = {{32{w_pq[31]}}, w_pq}; n_upd_ev = 1'b0;
                    n_k = r_k + CW'(1);
                    if (32'(r_k) == 32'(LEVELS - 1)) n_ev = 1'b1;
                end else begin
                    n_upd_ev = 1'b1;
                    if (w_d_merge[32]) begin
                        n_j = r_j + CW'(1);
                    end else if (w_d_merge == 33'sd0) begin
                        n_amt = {{31{w_shrink[32]}}, w_shrink};
                        n_i = r_i + CW'(1); n_j = r_j + CW'(1);
                    end else begin
                        n_amt = {{32{w_pq[31]}}, w_pq};
                        n_i = r_i + CW'(1);
                    end
                end
            end
            S_UPD: begin
                w_h_we = 1'b1;
                if (r_upd_ev) w_h_wdata = {w_h_rd[127:64], w_h_rd[63:0] + r_amt};
                else w_h_wdata = {w_h_rd[127:64] + r_amt, w_h_rd[63:0]};
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_out.bin_index = r_rd_bin;
                n_out.exposure_total = r_rd_oob ? 64'sd0 : w_h_rd[127:64];
                n_out.event_total    = r_rd_oob ? 64'sd0 : w_h_rd[63:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_i <= n_i; r_j <= n_j; r_ev <= n_ev; r_side <= n_side;
        r_upd_ev <= n_upd_ev; r_best <= n_best; r_haddr <= n_haddr; r_amt <= n_amt;
        r_rd_bin <= n_rd_bin; r_rd_oob <= n_rd_oob; r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    bdh_ram #(.WIDTH(64), .DEPTH(2 * LEVELS)) u_prev (
        .i_clk(i_clk), .i_we(w_snap_we_p), .i_waddr(w_cmd_addr),
        .i_wdata({i_cmd.price, i_cmd.quantity}), .i_raddr(w_prev_raddr), .o_rdata(w_prev_rd)
    );

    bdh_ram #(.WIDTH(64), .DEPTH(2 * LEVELS)) u_cur (
        .i_clk(i_clk), .i_we(w_snap_we_c), .i_waddr(w_cmd_addr),
        .i_wdata({i_cmd.price, i_cmd.quantity}), .i_raddr(w_cur_raddr), .o_rdata(w_cur_rd)
    );

    bdh_ram #(.WIDTH(128), .DEPTH(BINS)) u_hist (
        .i_clk(i_clk), .i_we(w_h_we), .i_waddr(w_h_waddr),
        .i_wdata(w_h_wdata), .i_raddr(w_h_raddr), .o_rdata(w_h_rd)
    );

    a_no_pop_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_cmd_pop) else $error("command taken outside idle");
    a_upd_then_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_state == S_FETCH)) else $error("update not followed by fetch");
    a_read_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> r_out_valid) else $error("read result lost");
    a_read_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.kind == CMD_READ) |-> !r_out_valid)
        else $error("read issued over waiting result");
endmodule

>>> hdl/book_depletion_histogram.sv
// order book depletion histogram
// input channel: push/full with an i_item transaction that either loads one book
// level (price and quantity of one side and snapshot) or reads one histogram bin
// output channel: empty/pop with o_item, one transaction per bin read, in order
// loads are taken one per cycle while full is low and written to the snapshot memory
// when the back end takes them from the queue in idle; loading the last current level
// of a side starts its walk: an exposure pass over the previous levels, then merge
// steps, the histogram memory doing one read-modify-write at a time
// a bin read goes through the queue, the read state and the output register before
// empty goes low
// after reset the histogram memory is cleared one bin per cycle, all BINS bins,
// during which commands wait in the two-entry queue
// a waiting result holds the next read at the head of the queue until popped;
// everything behind it waits too, and full rises once the queue holds two transactions
module book_depletion_histogram import bdh_pkg::*; #(
    parameter int LEVELS = 8,
    parameter int BINS   = 16384
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_item
);
    logic w_cmd_valid, w_cmd_pop;
    t_cmd w_cmd;

    bdh_front #(.LEVELS(LEVELS), .BINS(BINS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_pop(w_cmd_pop)
    );

    bdh_back #(.LEVELS(LEVELS), .BINS(BINS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_cmd_pop), .empty(empty), .pop(pop), .o_item(o_item)
    );
endmodule

>>> sim/tb.sv
module tb;
    import bdh_pkg::*;

    localparam int NLEV  = 8;
    localparam int NBIN  = 16384;
    localparam int NITEM = 800;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    t_in  i_item = '0;
    t_out o_item;

    int   errors = 0;
    int   items_sent = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_on = 1'b0;

    logic signed [31:0] prev_px[2*NLEV], prev_qty[2*NLEV];
    logic signed [31:0] cur_px[2*NLEV], cur_qty[2*NLEV];
    logic [63:0] expo_hist[NBIN];
    logic [63:0] depl_hist[NBIN];
    t_out bin_reads_due[$];

    book_depletion_histogram u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic report(input string what);
        $display("tb: mismatch %s at %0t", what, $realtime);
        errors++;
    endtask

    function automatic longint side_dist(input logic s, input logic signed [31:0] p,
                                         input logic signed [31:0] r);
        return s ? (longint'(r) - longint'(p)) : (longint'(p) - longint'(r));
    endfunction

    function automatic void bin_add(input bit depl, input longint d, input longint amt);
        if (d >= 0 && d < NBIN) begin
            if (depl) depl_hist[d] += amt;
            else expo_hist[d] += amt;
        end
    endfunction

    function automatic void walk_side(input logic s);
        int b, i, j;
        logic signed [31:0] best;
        longint d, dn;
        b = s ? NLEV : 0;
        best = prev_px[b];
        i = 0;
        j = 0;
        for (int k = 1; k < NLEV; k++)
            if (prev_qty[b+k] != 0)
                bin_add(0, side_dist(s, prev_px[b+k], best), longint'(prev_qty[b+k]));
        while (i < NLEV && j < NLEV && prev_qty[b+i] != 0 && cur_qty[b+j] != 0) begin
            d = side_dist(s, cur_px[b+j], prev_px[b+i]);
            if (d < 0) begin
                j++;
            end else if (d == 0) begin
                dn = longint'(cur_qty[b+j]) - longint'(prev_qty[b+i]);
                if (i > 0 && dn < 0)
                    bin_add(1, side_dist(s, prev_px[b+i], best), -dn);
                i++;
                j++;
            end else begin
                if (i > 0)
                    bin_add(1, side_dist(s, prev_px[b+i], best), longint'(prev_qty[b+i]));
                i++;
            end
        end
    endfunction

    function automatic t_out book_apply(input t_in it);
        t_out r;
        int x;
        r = '0;
        x = it.side * NLEV + it.level;
        if (it.func == FUNC_READ) begin
            r.bin_index = it.bin;
            r.exposure_total = expo_hist[it.bin];
            r.event_total = depl_hist[it.bin];
        end else if (it.snapshot == SNAP_CUR) begin
            cur_px[x] = it.price;
            cur_qty[x] = it.quantity;
            if (it.level == NLEV - 1) walk_side(it.side);
        end else begin
            prev_px[x] = it.price;
            prev_qty[x] = it.quantity;
        end
        return r;
    endfunction

    task automatic send_txn(input t_in it, input bit typed, input t_out want);
        t_out p;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        p = book_apply(it);
        if (it.func == FUNC_READ) bin_reads_due.push_back(typed ? want : p);
        items_sent++;
    endtask

    function automatic t_in mk_load(input logic s, input logic snap, input int lv,
                                    input logic signed [31:0] px,
                                    input logic signed [31:0] q);
        t_in it;
        it = '0;
        it.side = s;
        it.snapshot = snap;
        it.level = 3'(lv);
        it.price = px;
        it.quantity = q;
        it.bin = 14'($urandom);
        return it;
    endfunction

    function automatic t_in mk_read(input int b);
        t_in it;
        it = '0;
        it.func = FUNC_READ;
        it.side = 1'($urandom);
        it.snapshot = 1'($urandom);
        it.level = 3'($urandom);
        it.price = $urandom;
        it.quantity = $urandom;
        it.bin = 14'(b);
        return it;
    endfunction

    function automatic int rand_qty();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 15) return $urandom;
        return $urandom_range(1, 1000);
    endfunction

    task automatic book_seq(input logic s);
        int pr[NLEV], qt[NLEV], cpr[NLEV], cqt[NLEV];
        int dir, j;
        dir = s ? -1 : 1;
        pr[0] = int'($urandom_range(0, 2_000_000)) - 1_000_000;
        qt[0] = rand_qty();
        for (int k = 1; k < NLEV; k++) begin
            pr[k] = pr[k-1] + dir * int'($urandom_range(1, 40));
            qt[k] = rand_qty();
        end
        j = 0;
        if ($urandom_range(3) == 0) begin
            cpr[0] = pr[0] - dir * int'($urandom_range(1, 3));
            cqt[0] = $urandom_range(1, 500);
            j = 1;
        end
        for (int i = 0; i < NLEV; i++) begin
            if (j < NLEV && $urandom_range(3) != 0) begin
                cpr[j] = pr[i];
                cqt[j] = qt[i] - int'($urandom_range(0, 300)) + 100;
                if ($urandom_range(9) != 0 && cqt[j] == 0) cqt[j] = 1;
                j++;
            end
        end
        while (j < NLEV) begin
            cpr[j] = (j > 0 ? cpr[j-1] : pr[0]) + dir * int'($urandom_range(1, 40));
            cqt[j] = rand_qty();
            j++;
        end
        for (int k = 0; k < NLEV; k++) send_txn(mk_load(s, 1'b0, k, pr[k], qt[k]), 0, '0);
        for (int k = 0; k < NLEV; k++) send_txn(mk_load(s, 1'b1, k, cpr[k], cqt[k]), 0, '0);
    endtask

    always @(negedge i_clk)
        pop <= !hold_on && (calm || $urandom_range(99) >= 25);

    initial begin
        wait (hold_req);
        hold_on = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on = 1'b0;
    end

    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && pop && !empty) begin
            if (bin_reads_due.size() == 0) begin
                report("unexpected transaction");
            end else begin
                w = bin_reads_due.pop_front();
                if (o_item.bin_index !== w.bin_index) report("bin_index");
                if (o_item.exposure_total !== w.exposure_total) report("exposure_total");
                if (o_item.event_total !== w.event_total) report("event_total");
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row rw;
        int r;
        for (int b = 0; b < NBIN; b++) begin
            expo_hist[b] = '0;
            depl_hist[b] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reads after reset are all zero
        rw.typed = 1;
        rw.item = mk_read(0);
        rw.want = '0;
        rows.push_back(rw);
        rw.item = mk_read(NBIN - 1);
        rw.want = '0;
        rw.want.bin_index = 14'(NBIN - 1);
        rows.push_back(rw);
        rw.typed = 0;
        rw.want = '0;
        // ask book: extreme quantities, far prices, zero stops the walk
        rw.item = mk_load(0, 0, 0, 100, 50);                   rows.push_back(rw);
        rw.item = mk_load(0, 0, 1, 101, 32'sh8000_0000);       rows.push_back(rw);
        rw.item = mk_load(0, 0, 2, 102, 32'sh7fff_ffff);       rows.push_back(rw);
        rw.item = mk_load(0, 0, 3, 105, 7);                    rows.push_back(rw);
        rw.item = mk_load(0, 0, 4, 32'sh8000_0000, 3);         rows.push_back(rw);
        rw.item = mk_load(0, 0, 5, 32'sh7fff_ffff, 4);         rows.push_back(rw);
        rw.item = mk_load(0, 0, 6, 110, 9);                    rows.push_back(rw);
        rw.item = mk_load(0, 0, 7, 111, 0);                    rows.push_back(rw);
        // better level, equal, shrink, vanished levels, huge distance
        rw.item = mk_load(0, 1, 0, 99, 5);                     rows.push_back(rw);
        rw.item = mk_load(0, 1, 1, 100, 50);                   rows.push_back(rw);
        rw.item = mk_load(0, 1, 2, 101, 32'sh8000_0000);       rows.push_back(rw);
        rw.item = mk_load(0, 1, 3, 102, 5);                    rows.push_back(rw);
        rw.item = mk_load(0, 1, 4, 106, 2);                    rows.push_back(rw);
        rw.item = mk_load(0, 1, 5, 32'sh7fff_ffff, 1);         rows.push_back(rw);
        rw.item = mk_load(0, 1, 6, 110, 9);                    rows.push_back(rw);
        rw.item = mk_load(0, 1, 7, 111, -5);                   rows.push_back(rw);
        rw.item = mk_read(1);                                  rows.push_back(rw);
        rw.item = mk_read(2);                                  rows.push_back(rw);
        rw.item = mk_read(5);                                  rows.push_back(rw);
        rw.item = mk_read(10);                                 rows.push_back(rw);
        foreach (rows[n]) send_txn(rows[n].item, rows[n].typed, rows[n].want);

        hold_req = 1'b1;
        book_seq(1'b0);
        book_seq(1'b1);
        while (items_sent < NITEM) begin
            calm = (items_sent > 350 && items_sent < 500);
            r = $urandom_range(99);
            if (r < 20) begin
                book_seq(1'($urandom));
            end else if (r < 35) begin
                send_txn(mk_load(1'($urandom), 1'($urandom), $urandom_range(NLEV - 1),
                                 $urandom, $urandom), 0, '0);
            end else if (r < 90) begin
                send_txn(mk_read($urandom_range(0, 60)), 0, '0);
            end else begin
                send_txn(mk_read($urandom_range(0, NBIN - 1)), 0, '0);
            end
        end
        calm = 1'b0;
        @(negedge i_clk);
        push <= 1'b0;

        while (bin_reads_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && bin_reads_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

>>> sim.f
hdl/bdh_pkg.sv
hdl/bdh_ram.sv
hdl/bdh_front.sv
hdl/bdh_back.sv
hdl/book_depletion_histogram.sv
sim/tb.sv
